// File: hw/rtl/breakpoint_curve_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Breakpoint curve interpolator assertion macros
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_CURVE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_CURVE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BCI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCI_ASSERT_IMPL(lbl, ante, cons)
`define BCI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/bcintp_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint curve interpolator package
// Beat types, codes and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bcintp_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned DIV_STEPS      = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_EMPTY_VALUE = 1'b1;

    localparam logic [1:0] SRC_EMPTY  = 2'd0;
    localparam logic [1:0] SRC_BEFORE = 2'd1;
    localparam logic [1:0] SRC_INTERP = 2'd2;
    localparam logic [1:0] SRC_AFTER  = 2'd3;

    typedef struct packed {
        logic               command;
        logic [5:0]         point_index;
        logic signed [31:0] position;
        logic signed [31:0] point_level;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [1:0]         value_source;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] level;
    } t_point;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/breakpoint_curve_interpolator.sv
// ----------------------------------------------------------------------------
// Breakpoint curve interpolator
// Piecewise linear evaluation of an automation curve stored as breakpoints.
// ----------------------------------------------------------------------------
// A write beat (command 0) stores one breakpoint (position, level) in the
// table and returns nothing; indexes at or beyond
// MAX_POINTS are dropped. A query beat (command 1) returns one beat with the
// curve value and a source code: empty curve, before the first point,
// interpolated, or at/after the last point. The table must be sorted by
// ascending position for a meaningful curve, and every entry below
// point_count must have been written before it is queried. A query walks the
// table one entry per cycle through the single read port; when it interpolates,
// it then forms the 32x32 product and runs the bit-serial divider. Input is
// taken only while no query is in flight, but a finished result may sit in the
// output register while the next beat enters.
// Configuration writes are taken at any time and must only happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "breakpoint_curve_interpolator_assert.svh"

module breakpoint_curve_interpolator #(
    parameter int unsigned MAX_POINTS = bcintp_pkg::MAX_POINTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input beats
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire bcintp_pkg::t_in_beat  i_in_data,
    // result beats
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output bcintp_pkg::t_out_beat      o_out_data,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [31:0]           i_cfg_wdata
);

    localparam int unsigned ADDR_W = $clog2(MAX_POINTS);
    // wide enough for point_count and for MAX_POINTS itself
    localparam int unsigned CNT_W  = ($clog2(MAX_POINTS + 1) > 7) ?
                                     $clog2(MAX_POINTS + 1) : 7;

    // configuration registers
    logic [6:0]          r_point_count;
    logic signed [31:0]  r_empty_value;

    // control
    bcintp_pkg::t_state  r_state;
    bcintp_pkg::t_state  n_state;

    // query context
    logic [CNT_W-1:0]    r_n;
    logic [ADDR_W-1:0]   r_idx;
    logic signed [31:0]  r_pos;
    logic signed [31:0]  r_prev_pos;
    logic signed [31:0]  r_prev_lvl;
    logic [31:0]         r_span;
    logic [31:0]         r_off;
    logic [31:0]         r_mag;
    logic                r_neg;
    logic [63:0]         r_prod;
    logic signed [31:0]  r_res;
    logic [1:0]          r_src;

    // output register
    logic                  r_out_valid;
    bcintp_pkg::t_out_beat r_out_data;

    // datapath nets
    logic                w_in_accept;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_raddr;
    bcintp_pkg::t_point  w_rdata;
    bcintp_pkg::t_point  w_wdata;
    logic [CNT_W-1:0]    w_count_ext;
    logic [CNT_W-1:0]    w_n;
    logic                w_idx_ok;
    logic                w_hit;
    logic                w_last;
    logic                w_out_free;
    logic [32:0]         w_dv;
    logic [32:0]         w_span;
    logic [32:0]         w_off;
    logic [32:0]         w_interp;
    bcintp_pkg::t_div_req w_div_req;
    bcintp_pkg::t_div_rsp w_div_rsp;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_empty_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcintp_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_wdata[6:0];
                bcintp_pkg::CFG_EMPTY_VALUE: r_empty_value <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the point count to the table depth.
    always_comb begin
        w_count_ext = CNT_W'(r_point_count);
        w_n = (w_count_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : w_count_ext;
        w_idx_ok = CNT_W'(i_in_data.point_index) < CNT_W'(MAX_POINTS);
    end

    // ------------------------------------------------------------------
    // Breakpoint table
    // ------------------------------------------------------------------
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_mem_we    = w_in_accept && (i_in_data.command == bcintp_pkg::CMD_WRITE)
                         && w_idx_ok;
    assign w_wdata     = '{position: i_in_data.position, level: i_in_data.point_level};

    bcintp_mem #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (ADDR_W'(i_in_data.point_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Scan compare and segment setup (data for entry r_idx is in w_rdata)
    // ------------------------------------------------------------------
    always_comb begin
        w_hit    = r_pos < w_rdata.position;
        w_last   = CNT_W'(r_idx) == (r_n - CNT_W'(1));
        w_span   = {w_rdata.position[31], w_rdata.position} - {r_prev_pos[31], r_prev_pos};
        w_off    = {r_pos[31], r_pos} - {r_prev_pos[31], r_prev_pos};
        w_dv     = {w_rdata.level[31], w_rdata.level} - {r_prev_lvl[31], r_prev_lvl};
        w_interp = r_neg ? ({r_prev_lvl[31], r_prev_lvl} - {1'b0, w_div_rsp.quotient})
                         : ({r_prev_lvl[31], r_prev_lvl} + {1'b0, w_div_rsp.quotient});
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    assign w_div_req = '{start:    (r_state == bcintp_pkg::S_DSTART),
                         dividend: r_prod,
                         divisor:  r_span};

    bcintp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bcintp_pkg::S_IDLE: begin
                if (w_in_accept && (i_in_data.command == bcintp_pkg::CMD_QUERY)) begin
                    n_state = bcintp_pkg::S_FETCH;
                end
            end
            bcintp_pkg::S_FETCH: begin
                n_state = (r_n == '0) ? bcintp_pkg::S_DONE : bcintp_pkg::S_SCAN;
            end
            bcintp_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_idx == '0) ? bcintp_pkg::S_DONE : bcintp_pkg::S_MUL;
                end else if (w_last) begin
                    n_state = bcintp_pkg::S_DONE;
                end
            end
            bcintp_pkg::S_MUL:    n_state = bcintp_pkg::S_DSTART;
            bcintp_pkg::S_DSTART: n_state = bcintp_pkg::S_DIV;
            bcintp_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = bcintp_pkg::S_DONE;
                end
            end
            bcintp_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = bcintp_pkg::S_IDLE;
                end
            end
            default: n_state = bcintp_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = (r_state == bcintp_pkg::S_IDLE);
        // entry 0 on the fetch cycle, then always the entry after the one in hand
        w_raddr = (r_state == bcintp_pkg::S_FETCH) ? '0 : (r_idx + ADDR_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcintp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Query datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            bcintp_pkg::S_IDLE: begin
                // latch the query and freeze the point count for its duration
                r_pos <= i_in_data.position;
                r_n   <= w_n;
            end
            bcintp_pkg::S_FETCH: begin
                r_idx <= '0;
                r_res <= r_empty_value;
                r_src <= bcintp_pkg::SRC_EMPTY;
            end
            bcintp_pkg::S_SCAN: begin
                if (w_hit) begin
                    // before the first point, or set up the bracketing segment
                    r_res  <= w_rdata.level;
                    r_src  <= bcintp_pkg::SRC_BEFORE;
                    r_span <= w_span[31:0];
                    r_off  <= w_off[31:0];
                    r_neg  <= w_dv[32];
                    r_mag  <= w_dv[32] ? 32'(-w_dv) : w_dv[31:0];
                end else begin
                    r_prev_pos <= w_rdata.position;
                    r_prev_lvl <= w_rdata.level;
                    r_idx      <= r_idx + ADDR_W'(1);
                    r_res      <= w_rdata.level;
                    r_src      <= bcintp_pkg::SRC_AFTER;
                end
            end
            bcintp_pkg::S_MUL: begin
                r_prod <= 64'(r_mag) * 64'(r_off);
            end
            bcintp_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    r_res <= w_interp[31:0];
                    r_src <= bcintp_pkg::SRC_INTERP;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: hold the beat until taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == bcintp_pkg::S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bcintp_pkg::S_DONE) && w_out_free) begin
            r_out_data <= '{curve_value: r_res, value_source: r_src};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BCI_ASSERT_NEXT(a_query_fetch, w_in_accept && (i_in_data.command == bcintp_pkg::CMD_QUERY), r_state == bcintp_pkg::S_FETCH)
    `BCI_ASSERT_NEXT(a_div_started, r_state == bcintp_pkg::S_DSTART, (r_state == bcintp_pkg::S_DIV) && w_div_rsp.busy)
    `BCI_ASSERT_IMPL(a_empty_source, r_state == bcintp_pkg::S_DONE, (r_src == bcintp_pkg::SRC_EMPTY) == (r_n == '0))

endmodule

`default_nettype wire

// File: hw/rtl/bcintp_mem.sv
// ----------------------------------------------------------------------------
// Breakpoint table
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bcintp_mem #(
    parameter int unsigned DEPTH  = bcintp_pkg::MAX_POINTS_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire bcintp_pkg::t_point  i_wdata,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output bcintp_pkg::t_point       o_rdata
);

    bcintp_pkg::t_point r_mem [DEPTH];
    bcintp_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/bcintp_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// 64 by 32 unsigned divide, one quotient bit per cycle; the quotient must fit
// in 32 bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module bcintp_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bcintp_pkg::t_div_req i_req,
    output bcintp_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned CNT_W = $clog2(bcintp_pkg::DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_quo;
    logic [31:0]      r_div;

    logic [32:0]      w_shift;
    logic [33:0]      w_diff;
    logic             w_ge;
    logic [31:0]      n_rem;
    logic [31:0]      n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[31]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_ge    = ~w_diff[33];
        n_rem   = w_ge ? w_diff[31:0] : w_shift[31:0];
        n_quo   = {r_quo[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(bcintp_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[63:32];
            r_quo <= i_req.dividend[31:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quotient: r_quo};

endmodule

`default_nettype wire
